// ----- design/kmdc_pkg.sv -----
// shared types and constants for the key matrix debounce counter
`default_nettype none

package kmdc_pkg;

   localparam int NOW_W   = 32;
   localparam int SPAN_W  = 16;
   localparam int HOLD_W  = 8;
   localparam int TOTAL_W = 32;
   localparam int MAP_W   = 16;
   localparam int QUERY_W = 4;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_INTERVAL = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT       = 8'd1;

   localparam logic [SPAN_W-1:0] SCAN_INTERVAL_RESET = 16'd10;
   localparam logic [SPAN_W-1:0] LOCKOUT_RESET       = 16'd50;

   localparam logic [HOLD_W-1:0] HOLD_MAX  = 8'd255;
   localparam logic [HOLD_W-1:0] PRESS_MIN = 8'd1;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_RD   = 5'b00010,
      S_UPD  = 5'b00100,
      S_QRD  = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   typedef struct packed {
      logic [HOLD_W-1:0]  hold;
      logic [NOW_W-1:0]   stamp;
      logic [TOTAL_W-1:0] total;
      logic               pressed;
      logic               counted;
   } btn_upd_type;

endpackage

`default_nettype wire

// ----- design/key_matrix_debounce_counter.sv -----
// key matrix debounce counter top level with sequencer over the shared time compare
// a word with no scan goes through the query read and done states to the registered result;
// with a scan, every button is first walked through a read and an update state on ram
// a new word is accepted only in idle, once the last result is registered; the done state
// holds while an earlier result still waits for rsp_ready
// reset: synchronous, clears flags, valid bits, last scan time and loads register defaults
`default_nettype none

module key_matrix_debounce_counter #(
   parameter int ROWS    = 4,
   parameter int COLS    = 4,
   parameter int BUTTONS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_now_ms,
   input  wire logic [15:0] req_sense_map,
   input  wire logic        req_clear_totals,
   input  wire logic [3:0]  req_query_button,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scanned,
   output logic [15:0]      rsp_pressed_map,
   output logic [15:0]      rsp_cycled_map,
   output logic [31:0]      rsp_queried_total,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   localparam int IW  = BUTTONS > 1 ? $clog2(BUTTONS) : 1;
   localparam int STW = kmdc_pkg::HOLD_W + kmdc_pkg::NOW_W;

   kmdc_pkg::state_type state_ff, state_in;

   logic [15:0]        scan_interval_ff, scan_interval_in;
   logic [15:0]        lockout_ff, lockout_in;
   logic [31:0]        last_scan_ff, last_scan_in;
   logic [31:0]        now_ff, now_in;
   logic [15:0]        sense_ff, sense_in;
   logic [3:0]         query_ff, query_in;
   logic               scan_ff, scan_in;
   logic [IW-1:0]      idx_ff, idx_in;
   logic [BUTTONS-1:0] pressed_ff, pressed_in;
   logic [BUTTONS-1:0] st_valid_ff, st_valid_in;
   logic [BUTTONS-1:0] tot_valid_ff, tot_valid_in;
   logic [15:0]        cmap_ff, cmap_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_scanned_ff, rsp_scanned_in;
   logic [15:0]        rsp_pmap_ff, rsp_pmap_in;
   logic [15:0]        rsp_cmap_ff, rsp_cmap_in;
   logic [31:0]        rsp_total_ff, rsp_total_in;

   logic [6:0]    idx_wide, q_wide;
   logic [IW-1:0] q_addr, rd_addr;
   logic          q_in_range;
   logic [STW-1:0] st_rdata, st_wdata;
   logic [31:0]   tot_rdata;
   logic          st_wr, tot_wr;
   logic [7:0]    hold_old;
   logic [31:0]   stamp_old, total_old;
   logic          sensed, in_matrix;
   logic [31:0]   cmp_now, cmp_base;
   logic [15:0]   cmp_span;
   logic          cmp_later;
   logic [15:0]   pmap;
   kmdc_pkg::btn_upd_type upd;

   assign idx_wide   = 7'(idx_ff);
   assign q_wide     = 7'(query_ff);
   assign q_addr     = q_wide[IW-1:0];
   assign q_in_range = q_wide < 7'(BUTTONS);
   assign rd_addr    = (state_ff == kmdc_pkg::S_RD) ? idx_ff : q_addr;

   assign hold_old  = st_valid_ff[idx_ff] ? st_rdata[STW-1:kmdc_pkg::NOW_W] : '0;
   assign stamp_old = st_valid_ff[idx_ff] ? st_rdata[kmdc_pkg::NOW_W-1:0] : '0;
   assign total_old = tot_valid_ff[idx_ff] ? tot_rdata : '0;
   assign sensed    = (idx_wide < 7'd16) && sense_ff[idx_wide[3:0]];
   assign in_matrix = idx_wide < 7'(ROWS * COLS);

   // idle: scan decision on the incoming word, walk: lockout expiry
   always_comb begin
      if (state_ff == kmdc_pkg::S_IDLE) begin
         cmp_now  = req_now_ms;
         cmp_base = last_scan_ff;
         cmp_span = scan_interval_ff;
      end else begin
         cmp_now  = now_ff;
         cmp_base = stamp_old;
         cmp_span = lockout_ff;
      end
   end

   kmdc_time_cmp u_cmp (
      .now_ms  (cmp_now),
      .base_ms (cmp_base),
      .span_ms (cmp_span),
      .later   (cmp_later)
   );

   kmdc_btn_update u_upd (
      .hold_old  (hold_old),
      .stamp_old (stamp_old),
      .total_old (total_old),
      .sensed    (sensed),
      .in_matrix (in_matrix),
      .expired   (cmp_later),
      .now_ms    (now_ff),
      .upd       (upd)
   );

   assign st_wr    = state_ff == kmdc_pkg::S_UPD;
   assign tot_wr   = st_wr && upd.counted;
   assign st_wdata = {upd.hold, upd.stamp};

   kmdc_ram #(.WIDTH(STW), .DEPTH(BUTTONS)) u_st_ram (
      .clock   (clock),
      .wr_en   (st_wr),
      .wr_addr (idx_ff),
      .wr_data (st_wdata),
      .rd_addr (rd_addr),
      .rd_data (st_rdata)
   );

   kmdc_ram #(.WIDTH(32), .DEPTH(BUTTONS)) u_tot_ram (
      .clock   (clock),
      .wr_en   (tot_wr),
      .wr_addr (idx_ff),
      .wr_data (upd.total),
      .rd_addr (rd_addr),
      .rd_data (tot_rdata)
   );

   for (genvar j = 0; j < 16; j++) begin : g_pmap
      if (j < BUTTONS) begin : g_on
         assign pmap[j] = pressed_ff[j];
      end else begin : g_off
         assign pmap[j] = 1'b0;
      end
   end

   always_comb begin
      state_in         = state_ff;
      scan_interval_in = scan_interval_ff;
      lockout_in       = lockout_ff;
      last_scan_in     = last_scan_ff;
      now_in           = now_ff;
      sense_in         = sense_ff;
      query_in         = query_ff;
      scan_in          = scan_ff;
      idx_in           = idx_ff;
      pressed_in       = pressed_ff;
      st_valid_in      = st_valid_ff;
      tot_valid_in     = tot_valid_ff;
      cmap_in          = cmap_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_scanned_in   = rsp_scanned_ff;
      rsp_pmap_in      = rsp_pmap_ff;
      rsp_cmap_in      = rsp_cmap_ff;
      rsp_total_in     = rsp_total_ff;

      if (csr_valid) begin
         if (csr_index == kmdc_pkg::CSR_SCAN_INTERVAL) begin
            scan_interval_in = csr_data;
         end else if (csr_index == kmdc_pkg::CSR_LOCKOUT) begin
            lockout_in = csr_data;
         end
      end

      unique case (state_ff)
         kmdc_pkg::S_IDLE: begin
            if (req_valid) begin
               now_in   = req_now_ms;
               sense_in = req_sense_map;
               query_in = req_query_button;
               scan_in  = cmp_later;
               cmap_in  = '0;
               idx_in   = '0;
               if (req_clear_totals) begin
                  tot_valid_in = '0;
               end
               if (cmp_later) begin
                  last_scan_in = req_now_ms;
                  state_in     = kmdc_pkg::S_RD;
               end else begin
                  state_in = kmdc_pkg::S_QRD;
               end
            end
         end
         kmdc_pkg::S_RD: begin
            state_in = kmdc_pkg::S_UPD;
         end
         kmdc_pkg::S_UPD: begin
            pressed_in[idx_ff]  = upd.pressed;
            st_valid_in[idx_ff] = 1'b1;
            if (upd.counted) begin
               tot_valid_in[idx_ff] = 1'b1;
               if (idx_wide < 7'd16) begin
                  cmap_in[idx_wide[3:0]] = 1'b1;
               end
            end
            if (idx_ff == IW'(BUTTONS - 1)) begin
               state_in = kmdc_pkg::S_QRD;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = kmdc_pkg::S_RD;
            end
         end
         kmdc_pkg::S_QRD: begin
            state_in = kmdc_pkg::S_DONE;
         end
         kmdc_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_scanned_in = scan_ff;
               rsp_pmap_in    = pmap;
               rsp_cmap_in    = cmap_ff;
               rsp_total_in   = (q_in_range && tot_valid_ff[q_addr]) ? tot_rdata : '0;
               state_in       = kmdc_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = kmdc_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= kmdc_pkg::S_IDLE;
         scan_interval_ff <= kmdc_pkg::SCAN_INTERVAL_RESET;
         lockout_ff       <= kmdc_pkg::LOCKOUT_RESET;
         last_scan_ff     <= '0;
         idx_ff           <= '0;
         pressed_ff       <= '0;
         st_valid_ff      <= '0;
         tot_valid_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         scan_interval_ff <= scan_interval_in;
         lockout_ff       <= lockout_in;
         last_scan_ff     <= last_scan_in;
         idx_ff           <= idx_in;
         pressed_ff       <= pressed_in;
         st_valid_ff      <= st_valid_in;
         tot_valid_ff     <= tot_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      now_ff         <= now_in;
      sense_ff       <= sense_in;
      query_ff       <= query_in;
      scan_ff        <= scan_in;
      cmap_ff        <= cmap_in;
      rsp_scanned_ff <= rsp_scanned_in;
      rsp_pmap_ff    <= rsp_pmap_in;
      rsp_cmap_ff    <= rsp_cmap_in;
      rsp_total_ff   <= rsp_total_in;
   end

   assign req_ready         = state_ff == kmdc_pkg::S_IDLE;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_scanned       = rsp_scanned_ff;
   assign rsp_pressed_map   = rsp_pmap_ff;
   assign rsp_cycled_map    = rsp_cmap_ff;
   assign rsp_queried_total = rsp_total_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready did not drop after an accepted word");

   a_no_scan_no_cycle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_scanned) |-> (rsp_cycled_map == 16'd0))
      else $error("cycled buttons reported without a scan");

   a_cycled_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_cycled_map & rsp_pressed_map) == 16'd0))
      else $error("a counted button is still flagged pressed");

   a_walk_starts_at_zero: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff == kmdc_pkg::S_IDLE) && state_ff == kmdc_pkg::S_RD)
      |-> (idx_ff == '0))
      else $error("button walk did not start at index zero");

endmodule

`default_nettype wire

// ----- design/kmdc_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module kmdc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- design/kmdc_time_cmp.sv -----
// shared time compare unit: now later than base plus span, at 33 bits
`default_nettype none

module kmdc_time_cmp (
   input  wire logic [kmdc_pkg::NOW_W-1:0]  now_ms,
   input  wire logic [kmdc_pkg::NOW_W-1:0]  base_ms,
   input  wire logic [kmdc_pkg::SPAN_W-1:0] span_ms,
   output logic                             later
);

   logic [kmdc_pkg::NOW_W:0] limit;

   assign limit = {1'b0, base_ms} + (kmdc_pkg::NOW_W + 1)'(span_ms);
   assign later = {1'b0, now_ms} > limit;

endmodule

`default_nettype wire

// ----- design/kmdc_btn_update.sv -----
// per-button hold, press stamp and total update for one scan step
`default_nettype none

module kmdc_btn_update (
   input  wire logic [kmdc_pkg::HOLD_W-1:0]  hold_old,
   input  wire logic [kmdc_pkg::NOW_W-1:0]   stamp_old,
   input  wire logic [kmdc_pkg::TOTAL_W-1:0] total_old,
   input  wire logic                         sensed,
   input  wire logic                         in_matrix,
   input  wire logic                         expired,
   input  wire logic [kmdc_pkg::NOW_W-1:0]   now_ms,
   output kmdc_pkg::btn_upd_type             upd
);

   logic [kmdc_pkg::HOLD_W-1:0] hold_new;
   logic                        stamp_idle;

   assign stamp_idle = stamp_old == '0;

   always_comb begin
      if (!in_matrix) begin
         hold_new = hold_old;
      end else if (sensed) begin
         hold_new = (hold_old == kmdc_pkg::HOLD_MAX) ? hold_old
                                                     : hold_old + 8'd1;
      end else begin
         hold_new = '0;
      end

      upd.hold    = hold_new;
      upd.stamp   = stamp_old;
      upd.total   = total_old;
      upd.pressed = 1'b0;
      upd.counted = 1'b0;
      if (hold_new > kmdc_pkg::PRESS_MIN) begin
         upd.pressed = 1'b1;
         if (stamp_idle || expired) begin
            upd.stamp = now_ms;
         end
      end else if (!stamp_idle && expired) begin
         upd.counted = 1'b1;
         upd.total   = total_old + 32'd1;
         upd.stamp   = '0;
      end
   end

endmodule

`default_nettype wire
